// ===== rtl/assert_macros.svh =====
// assertion macros used by the parser datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define PHP_ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
// expression must never be true outside reset
`define PHP_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define PHP_ASSERT_PROP(label, clk, rst, prop)
`define PHP_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== rtl/php_pkg.sv =====
// shared types and status codes of the png header size parser
package php_pkg;

   // result status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_EOF        = 3'd1;
   localparam logic [2:0] STATUS_BAD_SIG    = 3'd2;
   localparam logic [2:0] STATUS_BAD_COMPR  = 3'd3;
   localparam logic [2:0] STATUS_INTERLACED = 3'd4;
   localparam logic [2:0] STATUS_BAD_COLOUR = 3'd5;

   // commands from controller to datapath
   typedef struct packed {
      logic       cnt_clr;
      logic       cnt_inc;
      logic       ld_len;
      logic       ld_kind;
      logic       ld_width;
      logic       ld_height;
      logic       ld_depth;
      logic       ld_colour;
      logic       ld_compr;
      logic       ihdr_go;
      logic       emit;
      logic [2:0] emit_status;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic       sig_match;
      logic [3:0] idx;
      logic       head_ihdr;
      logic       len_zero;
      logic       len_reached;
      logic       busy;
      logic       skid_full;
   } stat_type;

endpackage

// ===== rtl/php_controller.sv =====
// phase sequencer of the png header size parser
module php_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tlast,
   output logic               req_tready,
   input  php_pkg::stat_type  stat,
   output php_pkg::cmd_type   cmd
);
   import php_pkg::*;

   typedef enum logic [2:0] {
      PH_SIG,
      PH_HEAD,
      PH_IHDR,
      PH_DATA,
      PH_CRC,
      PH_DONE
   } phase_type;

   // byte positions inside the fixed-size sections
   localparam logic [3:0] SIG_LAST_IDX   = 4'd7;
   localparam logic [3:0] HEAD_LEN_BYTES = 4'd4;
   localparam logic [3:0] HEAD_LAST_IDX  = 4'd7;
   localparam logic [3:0] IHDR_HGT_IDX   = 4'd4;
   localparam logic [3:0] IHDR_DEPTH_IDX = 4'd8;
   localparam logic [3:0] IHDR_DEPTH_END = 4'd8;
   localparam logic [3:0] IHDR_COL_IDX   = 4'd9;
   localparam logic [3:0] IHDR_CMP_IDX   = 4'd10;
   localparam logic [3:0] IHDR_ILC_IDX   = 4'd12;
   localparam logic [3:0] CRC_LAST_IDX   = 4'd3;

   phase_type phase_ff, phase_in;
   logic      sig_ok_ff, sig_ok_in;
   logic      accept;
   logic      decided;

   // hold off while the size pipeline runs or both result slots are full
   assign req_tready = !stat.busy && !stat.skid_full;
   assign accept     = req_tvalid && req_tready;

   // next phase and datapath commands for the accepted word
   always_comb begin
      phase_in  = phase_ff;
      sig_ok_in = sig_ok_ff;
      cmd       = '0;
      decided   = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_SIG: begin
               cmd.cnt_inc = 1'b1;
               sig_ok_in   = sig_ok_ff && stat.sig_match;
               if (stat.idx == SIG_LAST_IDX) begin
                  cmd.cnt_clr = 1'b1;
                  if (!(sig_ok_ff && stat.sig_match)) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = STATUS_BAD_SIG;
                     decided         = 1'b1;
                  end else begin
                     phase_in = PH_HEAD;
                  end
               end
            end
            PH_HEAD: begin
               cmd.cnt_inc = 1'b1;
               if (stat.idx < HEAD_LEN_BYTES) begin
                  cmd.ld_len = 1'b1;
               end else begin
                  cmd.ld_kind = 1'b1;
               end
               if (stat.idx == HEAD_LAST_IDX) begin
                  cmd.cnt_clr = 1'b1;
                  priority if (stat.head_ihdr) begin
                     phase_in = PH_IHDR;
                  end else if (stat.len_zero) begin
                     phase_in = PH_CRC;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_IHDR: begin
               cmd.cnt_inc = 1'b1;
               priority if (stat.idx < IHDR_HGT_IDX) begin
                  cmd.ld_width = 1'b1;
               end else if (stat.idx < IHDR_DEPTH_IDX) begin
                  cmd.ld_height = 1'b1;
               end else if (stat.idx == IHDR_DEPTH_END) begin
                  cmd.ld_depth = 1'b1;
               end else if (stat.idx == IHDR_COL_IDX) begin
                  cmd.ld_colour = 1'b1;
               end else if (stat.idx == IHDR_CMP_IDX) begin
                  cmd.ld_compr = 1'b1;
               end else if (stat.idx == IHDR_ILC_IDX) begin
                  cmd.ihdr_go = 1'b1;
                  decided     = 1'b1;
               end else begin
                  cmd.cnt_inc = 1'b1;
               end
            end
            PH_DATA: begin
               cmd.cnt_inc = 1'b1;
               if (stat.len_reached) begin
                  cmd.cnt_clr = 1'b1;
                  phase_in    = PH_CRC;
               end
            end
            PH_CRC: begin
               cmd.cnt_inc = 1'b1;
               if (stat.idx == CRC_LAST_IDX) begin
                  cmd.cnt_clr = 1'b1;
                  phase_in    = PH_HEAD;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         // file ended before any decision
         if (!decided && req_tlast && phase_ff != PH_DONE) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = STATUS_EOF;
            decided         = 1'b1;
         end
         // last word starts a new file, a decision parks the parser
         if (req_tlast) begin
            phase_in    = PH_SIG;
            sig_ok_in   = 1'b1;
            cmd.cnt_clr = 1'b1;
         end else if (decided) begin
            phase_in = PH_DONE;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIG;
         sig_ok_ff <= 1'b1;
      end else begin
         phase_ff  <= phase_in;
         sig_ok_ff <= sig_ok_in;
      end
   end

endmodule

// ===== rtl/php_datapath.sv =====
// field registers, size pipeline and result buffer of the png header size parser
`include "assert_macros.svh"

module php_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_tdata,     // byte_value
   input  php_pkg::cmd_type   cmd,
   output php_pkg::stat_type  stat,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,     // size_bytes
   output logic [3:0]         rsp_tuser      // status[2:0], size_overflow[3]
);
   import php_pkg::*;

   localparam logic [7:0]  SIG_BYTES [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                            8'd13, 8'd10, 8'd26, 8'd10};
   localparam logic [31:0] KIND_IHDR     = 32'h4948_4452;
   localparam logic [31:0] SIZE_MAX      = 32'hFFFF_FFFF;

   // channels per colour type, zero for an invalid type
   function automatic logic [2:0] channel_count(input logic [7:0] kind);
      logic [2:0] ch;
      unique case (kind)
         8'd0:    ch = 3'd1;
         8'd2:    ch = 3'd3;
         8'd3:    ch = 3'd1;
         8'd4:    ch = 3'd2;
         8'd6:    ch = 3'd4;
         default: ch = 3'd0;
      endcase
      return ch;
   endfunction

   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] len_ff;
   logic [23:0] kind_ff;
   logic [31:0] width_ff, height_ff;
   logic [7:0]  depth_ff, colour_ff, compr_ff;

   logic        s1_v_ff, s2_v_ff;
   logic [2:0]  s1_status_ff, s1_status_in, s2_status_ff;
   logic [63:0] px_ff, px_in;
   logic [9:0]  bits_ff, bits_in;
   logic [49:0] prod_ff, prod_in;
   logic        zero_ff, hi_ff;

   logic        fin_ovf;
   logic [31:0] fin_size;
   logic        new_v;
   logic [2:0]  new_status;
   logic [31:0] new_size;
   logic        new_ovf;

   logic        out_v_ff, skid_v_ff;
   logic [2:0]  out_status_ff, skid_status_ff;
   logic [31:0] out_size_ff, skid_size_ff;
   logic        out_ovf_ff, skid_ovf_ff;
   logic        take;

   // byte counter
   always_comb begin
      priority if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 32'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // status toward the controller
   assign stat.sig_match   = (req_tdata == SIG_BYTES[cnt_ff[2:0]]);
   assign stat.idx         = cnt_ff[3:0];
   assign stat.head_ihdr   = ({kind_ff, req_tdata} == KIND_IHDR);
   assign stat.len_zero    = (len_ff == '0);
   assign stat.len_reached = (({1'b0, cnt_ff} + 33'd1) >= {1'b0, len_ff});
   assign stat.busy        = s1_v_ff || s2_v_ff;
   assign stat.skid_full   = skid_v_ff;

   // first size stage: checks, pixel count and bits per pixel
   always_comb begin
      priority if (compr_ff != 8'd0) begin
         s1_status_in = STATUS_BAD_COMPR;
      end else if (req_tdata != 8'd0) begin
         s1_status_in = STATUS_INTERLACED;
      end else if (channel_count(colour_ff) == 3'd0) begin
         s1_status_in = STATUS_BAD_COLOUR;
      end else begin
         s1_status_in = STATUS_OK;
      end
   end
   assign px_in   = {32'd0, width_ff} * {32'd0, height_ff};
   // at most four channels of 255 bits, fits in ten bits
   assign bits_in = 10'(channel_count(colour_ff)) * 10'(depth_ff);

   // second size stage: total bits
   assign prod_in = {10'd0, px_ff[39:0]} * {40'd0, bits_ff};

   // final saturation of the byte count
   always_comb begin
      priority if (s2_status_ff != STATUS_OK || zero_ff) begin
         fin_size = '0;
         fin_ovf  = 1'b0;
      end else if (hi_ff || prod_ff[49:35] != '0) begin
         fin_size = SIZE_MAX;
         fin_ovf  = 1'b1;
      end else begin
         fin_size = prod_ff[34:3];
         fin_ovf  = 1'b0;
      end
   end

   // one result source at a time: direct decision or size pipeline
   assign new_v      = cmd.emit || s2_v_ff;
   assign new_status = s2_v_ff ? s2_status_ff : cmd.emit_status;
   assign new_size   = s2_v_ff ? fin_size : '0;
   assign new_ovf    = s2_v_ff && fin_ovf;
   assign take       = out_v_ff && rsp_tready;

   // header field registers
   always_ff @(posedge clock) begin
      if (cmd.ld_len) begin
         len_ff <= {len_ff[23:0], req_tdata};
      end
      if (cmd.ld_kind) begin
         kind_ff <= {kind_ff[15:0], req_tdata};
      end
      if (cmd.ld_width) begin
         width_ff <= {width_ff[23:0], req_tdata};
      end
      if (cmd.ld_height) begin
         height_ff <= {height_ff[23:0], req_tdata};
      end
      if (cmd.ld_depth) begin
         depth_ff <= req_tdata;
      end
      if (cmd.ld_colour) begin
         colour_ff <= req_tdata;
      end
      if (cmd.ld_compr) begin
         compr_ff <= req_tdata;
      end
   end

   // size pipeline payload
   always_ff @(posedge clock) begin
      if (cmd.ihdr_go) begin
         s1_status_ff <= s1_status_in;
         px_ff        <= px_in;
         bits_ff      <= bits_in;
      end
      if (s1_v_ff) begin
         s2_status_ff <= s1_status_ff;
         prod_ff      <= prod_in;
         zero_ff      <= (bits_ff == '0) || (px_ff == '0);
         hi_ff        <= (px_ff[63:40] != '0);
      end
   end

   // result buffer payload: output register with one skid slot
   always_ff @(posedge clock) begin
      if (skid_v_ff && take) begin
         out_status_ff <= skid_status_ff;
         out_size_ff   <= skid_size_ff;
         out_ovf_ff    <= skid_ovf_ff;
      end else if (!skid_v_ff && (!out_v_ff || take)) begin
         out_status_ff <= new_status;
         out_size_ff   <= new_size;
         out_ovf_ff    <= new_ovf;
      end
      if (!skid_v_ff && out_v_ff && !take && new_v) begin
         skid_status_ff <= new_status;
         skid_size_ff   <= new_size;
         skid_ovf_ff    <= new_ovf;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         s1_v_ff <= cmd.ihdr_go;
         s2_v_ff <= s1_v_ff;
         if (skid_v_ff) begin
            if (take) begin
               skid_v_ff <= 1'b0;
            end
         end else if (!out_v_ff || take) begin
            out_v_ff <= new_v;
         end else if (new_v) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_size_ff;
   assign rsp_tuser  = {out_ovf_ff, out_status_ff};

   // checks
   `PHP_ASSERT_PROP(a_skid_needs_out, clock, reset, skid_v_ff |-> out_v_ff)
   `PHP_ASSERT_PROP(a_s1_feeds_s2, clock, reset, s1_v_ff |=> s2_v_ff)
   `PHP_ASSERT_NEVER(a_one_source, clock, reset, cmd.emit && s2_v_ff)
   `PHP_ASSERT_NEVER(a_one_in_flight, clock, reset, s1_v_ff && s2_v_ff)

endmodule

// ===== rtl/png_header_size_parser.sv =====
// png header size parser: top level joining controller and datapath
//
// The req channel carries a png file one word (byte) at a time, tlast on the
// final byte of each file. The rsp channel carries at most one word per file:
// tuser holds the status and the saturation flag, tdata the image byte size.
// A status word comes on a bad signature at byte 8, on the 13th ihdr data
// byte, or as end-of-file when the last byte arrives first. Later bytes of the
// same file are taken and dropped until tlast, which restarts the parser.
// Throughput is one byte per cycle while req_tready is high. A signature or
// end-of-file result is registered from its byte into the result buffer. An
// ihdr result first passes the two-stage size multiplier (pixel count, then
// total bits); req_tready is low while either multiplier stage is busy.
// A result register plus one skid slot let one more result be decided while
// the receiver stalls; with both full, req_tready drops until rsp is taken.
// Synchronous reset puts the parser at the start of a file with no result
// pending; no memory needs clearing.
module png_header_size_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_value
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // size_bytes
   output logic [3:0]  rsp_tuser    // status[2:0], size_overflow[3]
);
   import php_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // phase sequencer
   php_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // fields, size math and result buffer
   php_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
